[rtl/core/led_matrix_scan_driver_defines.svh]
// Assertion macros shared by the LED matrix scan driver RTL.
`ifndef LED_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lmsd_pkg.sv]
// Shared types, constants and pixel map for the LED matrix scan driver.
`timescale 1ns / 1ps
package lmsd_pkg;

	localparam int PHYS_ROWS_DEF = 3;
	localparam int PHYS_COLS_DEF = 9;
	localparam int GRID_SIZE_DEF = 5;

	localparam int MAP_LEN     = 25;
	localparam int LINE_PIXELS = 5;
	localparam int WORD_W      = 32;
	localparam int PERIOD_W    = 16;
	localparam int MAX_ROW_W   = 3;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST = 16'd1000;
	localparam logic [PADDR_W-3:0]  REG_SCAN_PERIOD = 1'd0;

	// Physical position of each logical pixel, index y*5 + x.
	localparam logic [3:0] MAP_ROW [MAP_LEN] = '{
		4'd0, 4'd1, 4'd0, 4'd1, 4'd0,
		4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
		4'd1, 4'd0, 4'd1, 4'd2, 4'd1,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd2, 4'd1, 4'd2, 4'd1, 4'd2
	};

	localparam logic [3:0] MAP_COL [MAP_LEN] = '{
		4'd0, 4'd3, 4'd1, 4'd4, 4'd2,
		4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd1, 4'd8, 4'd2, 4'd8, 4'd0,
		4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
		4'd2, 4'd6, 4'd0, 4'd5, 4'd1
	};

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_SET  = 2'd1,
		REQ_FILL = 2'd2,
		REQ_LINE = 2'd3
	} req_t;

	typedef struct packed {
		req_t              req_type;
		logic [2:0]        pixel_x;
		logic [2:0]        pixel_y;
		logic              pixel_value;
		logic [2:0]        line_index;
		logic [WORD_W-1:0] line_bits;
		logic [4:0]        shift_offset;
	} req_item_t;

	typedef struct packed {
		logic [MAX_ROW_W-1:0] row;
		logic                 advanced;
	} scan_t;

endpackage

[rtl/core/lmsd_item_if.sv]
// Request channel: valid/ready handshake carrying one driver item.
`timescale 1ns / 1ps
interface lmsd_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [2:0]  pixel_x;
	logic [2:0]  pixel_y;
	logic        pixel_value;
	logic [2:0]  line_index;
	logic [31:0] line_bits;
	logic [4:0]  shift_offset;

	modport source (
		output valid, req_type, pixel_x, pixel_y, pixel_value, line_index, line_bits,
			shift_offset,
		input ready
	);
	modport sink (
		input valid, req_type, pixel_x, pixel_y, pixel_value, line_index, line_bits,
			shift_offset,
		output ready
	);
endinterface

[rtl/core/lmsd_result_if.sv]
// Result channel: valid/ready handshake carrying row and column drive.
`timescale 1ns / 1ps
interface lmsd_result_if #(
	parameter int PhysRows = lmsd_pkg::PHYS_ROWS_DEF,
	parameter int PhysCols = lmsd_pkg::PHYS_COLS_DEF
);
	logic                valid;
	logic                ready;
	logic [PhysRows-1:0] row_lines;
	logic [PhysCols-1:0] column_lines;
	logic                row_advanced;

	modport source (output valid, row_lines, column_lines, row_advanced, input ready);
	modport sink (input valid, row_lines, column_lines, row_advanced, output ready);
endinterface

[rtl/core/lmsd_apb_regs.sv]
// APB register block holding the scan period.
`timescale 1ns / 1ps
module lmsd_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lmsd_pkg::PADDR_W-1:0]    paddr,
	input  logic [lmsd_pkg::PDATA_W-1:0]    pwdata,
	output logic [lmsd_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	output logic [lmsd_pkg::PERIOD_W-1:0]   scan_period
);
	import lmsd_pkg::*;

	logic [PERIOD_W-1:0] scan_period_q;
	logic [PADDR_W-3:0]  word_sel;
	logic                wr_en;

	assign word_sel = paddr[PADDR_W-1:2];
	assign wr_en    = psel && penable && pwrite && (word_sel == REG_SCAN_PERIOD);
	assign pready   = 1'b1;
	assign prdata   = (word_sel == REG_SCAN_PERIOD) ? PDATA_W'(scan_period_q) : '0;
	assign scan_period = scan_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
		end else if (wr_en) begin
			scan_period_q <= pwdata[PERIOD_W-1:0];
		end
	end

endmodule

[rtl/core/lmsd_scan_timer.sv]
// Tick counter and active row register for the row scan.
`timescale 1ns / 1ps
module lmsd_scan_timer #(
	parameter int PhysRows = lmsd_pkg::PHYS_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  logic                          tick,
	input  logic [lmsd_pkg::PERIOD_W-1:0] scan_period,
	output lmsd_pkg::scan_t               scan
);
	import lmsd_pkg::*;

	localparam int RowW = (PhysRows > 1) ? $clog2(PhysRows) : 1;

	logic [PERIOD_W-1:0] tick_count_q;
	logic [RowW-1:0]     active_row_q;
	logic [RowW-1:0]     row_inc;
	logic [PERIOD_W:0]   period;
	logic [PERIOD_W:0]   count_inc;
	logic                wrap;

	always_comb begin
		// a zero period behaves as one
		period    = (scan_period == '0) ? (PERIOD_W+1)'(1) : {1'b0, scan_period};
		count_inc = {1'b0, tick_count_q} + (PERIOD_W+1)'(1);
		wrap      = tick && (count_inc >= period);
		row_inc   = (active_row_q == RowW'(PhysRows - 1)) ? '0 : active_row_q + RowW'(1);
		scan.row      = MAX_ROW_W'(wrap ? row_inc : active_row_q);
		scan.advanced = wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			active_row_q <= '0;
		end else if (commit && tick) begin
			if (wrap) begin
				tick_count_q <= '0;
				active_row_q <= row_inc;
			end else begin
				tick_count_q <= count_inc[PERIOD_W-1:0];
			end
		end
	end

endmodule

[rtl/core/lmsd_frame_store.sv]
// Frame bit store with pixel, fill and line writes, and column drive of the active row.
`timescale 1ns / 1ps
module lmsd_frame_store #(
	parameter int PhysRows = lmsd_pkg::PHYS_ROWS_DEF,
	parameter int PhysCols = lmsd_pkg::PHYS_COLS_DEF,
	parameter int GridSize = lmsd_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           commit,
	input  lmsd_pkg::req_item_t            req,
	input  logic [lmsd_pkg::MAX_ROW_W-1:0] row,
	output logic [PhysCols-1:0]            cols
);
	import lmsd_pkg::*;

	localparam int StoreLen = PhysRows * PhysCols;

	logic [StoreLen-1:0] frame_q;
	logic [StoreLen-1:0] frame_nxt;
	logic [MAP_LEN-1:0]  hit;
	logic [MAP_LEN-1:0]  val;
	logic [6:0]          set_idx;
	logic                set_ok;
	logic                line_ok;
	logic [5:0]          bit_idx;

	always_comb begin
		set_ok  = (req.req_type == REQ_SET) && ({1'b0, req.pixel_x} < 4'(GridSize))
			&& ({1'b0, req.pixel_y} < 4'(GridSize));
		line_ok = (req.req_type == REQ_LINE) && ({1'b0, req.line_index} < 4'(GridSize));
		set_idx = 7'(req.pixel_y) * 7'(GridSize) + 7'(req.pixel_x);
		bit_idx = '0;
		for (int k = 0; k < MAP_LEN; k++) begin
			// line pixel j reads word bit 4-j+offset; bits past the word are dark
			bit_idx = 6'(LINE_PIXELS - 1 - (k % LINE_PIXELS)) + 6'(req.shift_offset);
			val[k]  = (req.req_type == REQ_SET) ? req.pixel_value
				: ((bit_idx < 6'(WORD_W)) && req.line_bits[bit_idx[4:0]]);
			hit[k]  = (set_ok && (set_idx == 7'(k)))
				|| (line_ok && (req.line_index == 3'(k / LINE_PIXELS)));
		end

		frame_nxt = frame_q;
		if (req.req_type == REQ_FILL) begin
			frame_nxt = {StoreLen{req.pixel_value}};
		end else begin
			for (int k = 0; k < MAP_LEN; k++) begin
				if (hit[k] && (int'(MAP_ROW[k]) < PhysRows) && (int'(MAP_COL[k]) < PhysCols)) begin
					frame_nxt[int'(MAP_ROW[k]) * PhysCols + int'(MAP_COL[k])] = val[k];
				end
			end
		end

		cols = '1;
		for (int r = 0; r < PhysRows; r++) begin
			if (row == MAX_ROW_W'(r)) begin
				cols = ~frame_nxt[r*PhysCols +: PhysCols];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (commit) begin
			frame_q <= frame_nxt;
		end
	end

endmodule

[rtl/core/led_matrix_scan_driver.sv]
// LED matrix scan driver: multiplexed 5x5 grid on a row/column matrix.
// Channels: item (sink) takes ticks, pixel sets, fills and line loads;
// result (source) returns, for every item, the one-hot row drive, the
// active-low column levels of that row and a flag for a row change.
// The APB port holds the scan period (byte address 0), ticks per row.
// An item is taken into an input register; when it advances, its effect
// on frame and scan state is committed and its result registered.
// Throughput: one item per cycle unless the result stalls; the path
// between the two registers is one map decode and one row select over
// the frame store.
// A stalled result holds in its register while the input register still
// takes one more item; input stalls only when both are full.
// Reset clears the frame (all dark), selects row 0 with the tick count
// at zero and loads a scan period of 1000. No start-up sweep.
`timescale 1ns / 1ps
`include "led_matrix_scan_driver_defines.svh"
module led_matrix_scan_driver #(
	parameter int PHYS_ROWS = lmsd_pkg::PHYS_ROWS_DEF,
	parameter int PHYS_COLS = lmsd_pkg::PHYS_COLS_DEF,
	parameter int GRID_SIZE = lmsd_pkg::GRID_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lmsd_item_if.sink                    item,
	lmsd_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lmsd_pkg::PADDR_W-1:0] paddr,
	input  logic [lmsd_pkg::PDATA_W-1:0] pwdata,
	output logic [lmsd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import lmsd_pkg::*;

	logic                valid_s1;
	req_item_t           item_s1;
	logic                valid_s2;
	logic [PHYS_ROWS-1:0] row_lines_s2;
	logic [PHYS_COLS-1:0] column_lines_s2;
	logic                row_advanced_s2;

	logic                 adv;
	logic                 take;
	logic [PERIOD_W-1:0]  scan_period;
	scan_t                scan;
	logic [PHYS_COLS-1:0] cols;
	logic [PHYS_ROWS-1:0] row_onehot;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign take       = item.valid && item.ready;

	lmsd_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.scan_period (scan_period)
	);

	lmsd_scan_timer #(
		.PhysRows (PHYS_ROWS)
	) u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (adv),
		.tick        (item_s1.req_type == REQ_TICK),
		.scan_period (scan_period),
		.scan        (scan)
	);

	lmsd_frame_store #(
		.PhysRows (PHYS_ROWS),
		.PhysCols (PHYS_COLS),
		.GridSize (GRID_SIZE)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.req    (item_s1),
		.row    (scan.row),
		.cols   (cols)
	);

	always_comb begin
		for (int r = 0; r < PHYS_ROWS; r++) begin
			row_onehot[r] = (scan.row == MAX_ROW_W'(r));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.req_type     <= req_t'(item.req_type);
			item_s1.pixel_x      <= item.pixel_x;
			item_s1.pixel_y      <= item.pixel_y;
			item_s1.pixel_value  <= item.pixel_value;
			item_s1.line_index   <= item.line_index;
			item_s1.line_bits    <= item.line_bits;
			item_s1.shift_offset <= item.shift_offset;
		end
		if (adv) begin
			row_lines_s2    <= row_onehot;
			column_lines_s2 <= cols;
			row_advanced_s2 <= scan.advanced;
		end
	end

	assign result.valid        = valid_s2;
	assign result.row_lines    = row_lines_s2;
	assign result.column_lines = column_lines_s2;
	assign result.row_advanced = row_advanced_s2;

	`LMSD_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !item.ready, valid_s1 && valid_s2, "input stalled with a free stage")
	`LMSD_ASSERT_NXT(a_adv_only_on_tick, clk, arst_n, adv && (item_s1.req_type != REQ_TICK), !row_advanced_s2, "row advanced on a non-tick item")
	`LMSD_ASSERT_IMP(a_row_onehot, clk, arst_n, valid_s2, $onehot(row_lines_s2), "row drive not one-hot")

endmodule

[tb/led_matrix_scan_driver_tb.sv]
// Self-checking testbench for the LED matrix scan driver: random item and result traffic.
`timescale 1ns / 1ps
module led_matrix_scan_driver_tb;
	import lmsd_pkg::*;

	localparam int ROWS = PHYS_ROWS_DEF;
	localparam int COLS = PHYS_COLS_DEF;
	localparam int GRID = GRID_SIZE_DEF;
	localparam int LIMIT_CYCLES = 500000;
	localparam logic [PADDR_W-1:0] ADDR_SCAN_PERIOD = {REG_SCAN_PERIOD, 2'b00};

	// store slot (row*9 + col) of each logical pixel, indexed y*5 + x
	localparam logic [0:24][4:0] PIXEL_SLOT = {
		5'd0,  5'd12, 5'd1,  5'd13, 5'd2,
		5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
		5'd10, 5'd8,  5'd11, 5'd26, 5'd9,
		5'd7,  5'd6,  5'd5,  5'd4,  5'd3,
		5'd20, 5'd15, 5'd18, 5'd14, 5'd19
	};

	typedef struct packed {
		logic [ROWS-1:0] row_lines;
		logic [COLS-1:0] column_lines;
		logic            row_advanced;
	} drive_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	lmsd_item_if item_ch ();
	lmsd_result_if result_ch ();

	led_matrix_scan_driver i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	req_item_t pending_reqs[$];
	drive_t expected_drives[$];

	// shadow of the block's state
	logic [ROWS*COLS-1:0] frame_shadow;
	logic [1:0] row_shadow;
	logic [PERIOD_W-1:0] tick_shadow;
	logic [PERIOD_W-1:0] period_shadow;

	int mismatches;
	int received;
	int next_long_hold;
	int cycle_count;
	req_item_t live_req;
	int sender_gap;
	bit sender_burst;
	int hold_left;
	int stall_left;
	bit recv_burst;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic note_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
	endtask

	// Commits one transfer to the shadow state and queues the drive it must produce.
	task automatic predict_drive(input req_item_t r);
		drive_t d;
		logic [PERIOD_W:0] next;
		logic [PERIOD_W-1:0] period;
		int b;
		d = '0;
		case (r.req_type)
			REQ_TICK: begin
				period = (period_shadow == '0) ? PERIOD_W'(1) : period_shadow;
				next = {1'b0, tick_shadow} + 1'b1;
				if (next >= {1'b0, period}) begin
					tick_shadow = '0;
					row_shadow = (row_shadow == 2'(ROWS - 1)) ? 2'd0 : row_shadow + 2'd1;
					d.row_advanced = 1'b1;
				end else begin
					tick_shadow = next[PERIOD_W-1:0];
				end
			end
			REQ_SET: begin
				if (r.pixel_x < GRID && r.pixel_y < GRID)
					frame_shadow[PIXEL_SLOT[r.pixel_y * GRID + r.pixel_x]] = r.pixel_value;
			end
			REQ_FILL: begin
				frame_shadow = {(ROWS*COLS){r.pixel_value}};
			end
			default: begin
				if (r.line_index < GRID) begin
					for (int j = 0; j < GRID; j++) begin
						b = 4 - j + r.shift_offset;
						frame_shadow[PIXEL_SLOT[r.line_index * GRID + j]] =
							(b < 32) ? r.line_bits[b] : 1'b0;
					end
				end
			end
		endcase
		d.row_lines = ROWS'(1) << row_shadow;
		for (int c = 0; c < COLS; c++)
			d.column_lines[c] = ~frame_shadow[row_shadow * COLS + c];
		expected_drives.push_back(d);
	endtask

	function automatic req_item_t make_req(input req_t kind, input int x, input int y,
			input bit v, input int line, input logic [31:0] bits, input int off);
		req_item_t r;
		r.req_type = kind;
		r.pixel_x = 3'(x);
		r.pixel_y = 3'(y);
		r.pixel_value = v;
		r.line_index = 3'(line);
		r.line_bits = bits;
		r.shift_offset = 5'(off);
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// mostly in-range coordinates, sometimes the out-of-range codes
	function automatic int pick_coord();
		return ($urandom_range(0, 6) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
	endfunction

	function automatic int pick_offset();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(28, 31) : $urandom_range(0, 27);
	endfunction

	function automatic req_item_t random_req();
		return make_req(req_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
			$urandom_range(0, 1), pick_coord(), pick_word(), pick_offset());
	endfunction

	task automatic queue_random(input int count);
		int n;
		int off;
		int runs;
		n = 0;
		while (n < count) begin
			case ($urandom_range(0, 9))
				0: begin
					// whole-frame draw: five line loads at one scroll offset
					off = ($urandom_range(0, 1) == 0) ? 0 : pick_offset();
					for (int l = 0; l < GRID; l++)
						pending_reqs.push_back(make_req(REQ_LINE, pick_coord(), pick_coord(),
							$urandom_range(0, 1), l, pick_word(), off));
					n += GRID;
				end
				1: begin
					runs = $urandom_range(3, 12);
					for (int k = 0; k < runs; k++)
						pending_reqs.push_back(make_req(REQ_TICK, pick_coord(), pick_coord(),
							$urandom_range(0, 1), pick_coord(), $urandom, $urandom_range(0, 31)));
					n += runs;
				end
				default: begin
					pending_reqs.push_back(random_req());
					n++;
				end
			endcase
		end
	endtask

	// sampled between edges so the sender and receiver updates of an edge have settled
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || expected_drives.size() != 0 || item_ch.valid)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_SCAN_PERIOD;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			period_shadow = data[PERIOD_W-1:0];
		else if (prdata[PERIOD_W-1:0] !== period_shadow)
			note_mismatch("scan_period readback", period_shadow, prdata[PERIOD_W-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic queue_directed();
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_FILL, 7, 7, 1, 7, '1, 31));
		// all rows lit, including the two unmapped LEDs of row 1
		repeat (3) pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_FILL, 0, 0, 0, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 0, 0, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 4, 4, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 4, 0, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 0, 4, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 7, 0, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 0, 7, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_SET, 5, 5, 1, 0, '0, 0));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 4, 32'h0000_001F, 27));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 4, 32'hF800_0000, 27));
		// offset 31 pushes four of the five bits past the word
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 2, 32'hFFFF_FFFF, 31));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 7, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 5, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 1, 32'h0000_0015, 0));
		pending_reqs.push_back(make_req(REQ_LINE, 0, 0, 0, 3, 32'h0000_0000, 0));
		repeat (3) pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, '0, 0));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			sender_gap = 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				predict_drive(live_req);
			if (!item_ch.valid || item_ch.ready) begin
				if ($urandom_range(0, 79) == 0)
					sender_burst = !sender_burst;
				if (sender_gap > 0) begin
					sender_gap--;
					item_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					live_req = pending_reqs.pop_front();
					item_ch.req_type <= live_req.req_type;
					item_ch.pixel_x <= live_req.pixel_x;
					item_ch.pixel_y <= live_req.pixel_y;
					item_ch.pixel_value <= live_req.pixel_value;
					item_ch.line_index <= live_req.line_index;
					item_ch.line_bits <= live_req.line_bits;
					item_ch.shift_offset <= live_req.shift_offset;
					item_ch.valid <= 1'b1;
					sender_gap = sender_burst ? 0 : pick_gap();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_drives.size() == 0) begin
					note_mismatch($sformatf("result %0d with nothing expected", received),
						0, {result_ch.row_lines, result_ch.column_lines, result_ch.row_advanced});
				end else begin
					want = expected_drives.pop_front();
					if (result_ch.row_lines !== want.row_lines)
						note_mismatch($sformatf("row_lines, result %0d", received),
							want.row_lines, result_ch.row_lines);
					if (result_ch.column_lines !== want.column_lines)
						note_mismatch($sformatf("column_lines, result %0d", received),
							want.column_lines, result_ch.column_lines);
					if (result_ch.row_advanced !== want.row_advanced)
						note_mismatch($sformatf("row_advanced, result %0d", received),
							want.row_advanced, result_ch.row_advanced);
				end
				received++;
				// long hold-off so the block backs up and stalls its input
				if (received == next_long_hold) begin
					hold_left = 250;
					next_long_hold += 800;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 79) == 0)
					recv_burst = !recv_burst;
				stall_left = (recv_burst || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
				result_ch.ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [PERIOD_W-1:0] phase_periods [7];
		phase_periods = '{16'd0, 16'd2, 16'd65535, 16'd3, 16'd7, 16'd5, 16'd1000};
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.req_type = '0;
		item_ch.pixel_x = '0;
		item_ch.pixel_y = '0;
		item_ch.pixel_value = 1'b0;
		item_ch.line_index = '0;
		item_ch.line_bits = '0;
		item_ch.shift_offset = '0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_shadow = '0;
		row_shadow = '0;
		tick_shadow = '0;
		period_shadow = SCAN_PERIOD_RST;
		mismatches = 0;
		received = 0;
		next_long_hold = 150;
		cycle_count = 0;
		sender_burst = 1'b0;
		recv_burst = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of the period first, then traffic under it
		apb_access(1'b0, '0);
		queue_random(120);
		wait_idle();

		apb_access(1'b1, 32'd1);
		apb_access(1'b0, '0);
		queue_directed();
		queue_random(200);
		wait_idle();

		// zero period counts as one; a small period after 65535 catches a high tick count
		foreach (phase_periods[p]) begin
			apb_access(1'b1, {16'h0, phase_periods[p]});
			apb_access(1'b0, '0);
			queue_random(205);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
